// File: sv/bwi_pkg.sv
package bwi_pkg;

  localparam int BWI_BLOCK_BYTES = 64;
  localparam int SYM_W           = 8;
  localparam int NSYM            = 256;
  localparam int SYM_IDX_W       = 9;
  localparam int HDR_BYTES       = 4;
  localparam int HDR_W           = 32;

  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_SHORT     = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  // block end request from the loader to the sequencer
  typedef struct packed {
    logic    go;
    status_t status;
  } blk_req_t;

  typedef struct packed {
    logic [SYM_W-1:0] data;
    logic             last;
    status_t          status;
  } out_item_t;

endpackage

// File: sv/bwi_obuf.sv
module bwi_obuf import bwi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      push_ok,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign push_ok   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (push && push_ok) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ok) begin
      item_r <= push_item;
    end
  end

endmodule

// File: sv/bwi_seq.sv
module bwi_seq import bwi_pkg::*; #(
  parameter int BLOCK_BYTES = BWI_BLOCK_BYTES,
  parameter int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1,
  parameter int LW = $clog2(BLOCK_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             lc_we,
  input  logic [AW-1:0]    lc_waddr,
  input  logic [SYM_W-1:0] lc_wdata,
  input  blk_req_t         req,
  input  logic [LW-1:0]    req_len,
  input  logic [AW-1:0]    req_start,
  output logic             rdy,
  output logic             push,
  output out_item_t        push_item,
  input  logic             push_ok
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_CNT_A  = 12'b0000_0000_0100,
    S_CNT_B  = 12'b0000_0000_1000,
    S_CNT_C  = 12'b0000_0001_0000,
    S_BASE   = 12'b0000_0010_0000,
    S_LF_A   = 12'b0000_0100_0000,
    S_LF_B   = 12'b0000_1000_0000,
    S_LF_C   = 12'b0001_0000_0000,
    S_WALK_A = 12'b0010_0000_0000,
    S_WALK_B = 12'b0100_0000_0000,
    S_STAT   = 12'b1000_0000_0000
  } state_t;

  logic [SYM_W-1:0] lc_mem   [BLOCK_BYTES];
  logic [SYM_W-1:0] fc_mem   [BLOCK_BYTES];
  logic [AW-1:0]    lf_mem   [BLOCK_BYTES];
  logic [LW-1:0]    cnt_mem  [NSYM];
  logic [LW-1:0]    base_mem [NSYM];

  logic [SYM_W-1:0] lc_q, fc_q;
  logic [AW-1:0]    lf_q;
  logic [LW-1:0]    cnt_q, base_q;

  state_t               state_r, state_nxt;
  logic [LW-1:0]        idx_r, idx_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [AW-1:0]        row_r, row_nxt;
  logic [SYM_W-1:0]     sym_r, sym_nxt;
  logic [SYM_IDX_W-1:0] c_r, c_nxt;
  logic                 wv_r, wv_nxt;
  logic [SYM_W-1:0]     wa_r, wa_nxt;
  logic [LW-1:0]        sum_r, sum_nxt;
  status_t              stat_r, stat_nxt;

  logic             idx_last;
  logic             cnt_we, base_we, col_we;
  logic [SYM_W-1:0] cnt_waddr, cnt_raddr, base_waddr;
  logic [LW-1:0]    cnt_wdata, base_wdata;

  assign rdy       = (state_r == S_IDLE);
  assign idx_last  = (idx_r == len_r - LW'(1));
  assign cnt_raddr = (state_r == S_BASE) ? c_r[SYM_W-1:0] : lc_q;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    row_nxt    = row_r;
    sym_nxt    = sym_r;
    c_nxt      = c_r;
    wv_nxt     = 1'b0;
    wa_nxt     = wa_r;
    sum_nxt    = sum_r;
    stat_nxt   = stat_r;
    cnt_we     = 1'b0;
    cnt_waddr  = sym_r;
    cnt_wdata  = '0;
    base_we    = 1'b0;
    base_waddr = wa_r;
    base_wdata = sum_r;
    col_we     = 1'b0;
    push       = 1'b0;
    push_item  = '{data: '0, last: 1'b1, status: stat_r};
    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = c_r[SYM_W-1:0];
        c_nxt     = c_r + SYM_IDX_W'(1);
        if (c_r[SYM_W-1:0] == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.go) begin
          len_nxt   = req_len;
          row_nxt   = req_start;
          idx_nxt   = '0;
          stat_nxt  = req.status;
          state_nxt = (req.status == ST_DATA) ? S_CNT_A : S_STAT;
        end
      end
      S_CNT_A: state_nxt = S_CNT_B;
      S_CNT_B: begin
        sym_nxt   = lc_q;
        state_nxt = S_CNT_C;
      end
      S_CNT_C: begin
        // write lands before the next count read in S_CNT_B: no overlap
        cnt_we    = 1'b1;
        cnt_waddr = sym_r;
        cnt_wdata = cnt_q + LW'(1);
        idx_nxt   = idx_r + LW'(1);
        if (idx_last) begin
          idx_nxt   = '0;
          c_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = S_BASE;
        end else begin
          state_nxt = S_CNT_A;
        end
      end
      S_BASE: begin
        // read symbol c while writing back symbol c-1
        if (!c_r[SYM_IDX_W-1]) begin
          wv_nxt = 1'b1;
          wa_nxt = c_r[SYM_W-1:0];
          c_nxt  = c_r + SYM_IDX_W'(1);
        end
        if (wv_r) begin
          cnt_we     = 1'b1;
          cnt_waddr  = wa_r;
          cnt_wdata  = '0;
          base_we    = 1'b1;
          base_waddr = wa_r;
          base_wdata = sum_r;
          sum_nxt    = sum_r + cnt_q;
        end
        if (c_r[SYM_IDX_W-1]) begin
          state_nxt = S_LF_A;
        end
      end
      S_LF_A: state_nxt = S_LF_B;
      S_LF_B: begin
        sym_nxt   = lc_q;
        state_nxt = S_LF_C;
      end
      S_LF_C: begin
        // the base runs up per symbol and gives the sorted row directly
        base_we    = 1'b1;
        base_waddr = sym_r;
        base_wdata = base_q + LW'(1);
        col_we     = 1'b1;
        idx_nxt    = idx_r + LW'(1);
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = S_WALK_A;
        end else begin
          state_nxt = S_LF_A;
        end
      end
      S_WALK_A: state_nxt = S_WALK_B;
      S_WALK_B: begin
        push      = 1'b1;
        push_item = '{data: fc_q, last: idx_last, status: ST_DATA};
        if (push_ok) begin
          row_nxt   = lf_q;
          idx_nxt   = idx_r + LW'(1);
          state_nxt = idx_last ? S_IDLE : S_WALK_A;
        end
      end
      S_STAT: begin
        push = 1'b1;
        if (push_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      c_r     <= '0;
      wv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      c_r     <= c_nxt;
      wv_r    <= wv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    len_r  <= len_nxt;
    row_r  <= row_nxt;
    sym_r  <= sym_nxt;
    wa_r   <= wa_nxt;
    sum_r  <= sum_nxt;
    stat_r <= stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (lc_we) begin
      lc_mem[lc_waddr] <= lc_wdata;
    end
    lc_q <= lc_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (base_we) begin
      base_mem[base_waddr] <= base_wdata;
    end
    base_q <= base_mem[lc_q];
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      fc_mem[base_q[AW-1:0]] <= sym_r;
      lf_mem[base_q[AW-1:0]] <= idx_r[AW-1:0];
    end
    fc_q <= fc_mem[row_r];
    lf_q <= lf_mem[row_r];
  end

endmodule

// File: sv/burrows_wheeler_inverse_unit.sv
// channel | signals                                    | direction
// in      | in_tvalid in_tready in_tdata in_tlast      | header then last column in
// out     | out_tvalid out_tready out_tdata out_tlast  | restored bytes or status out
//         | out_tuser                                  |
//
// loading takes one byte per cycle; the final byte starts the decode, during
// which in_tready is low: it counts the symbols, forms the prefix bases, builds
// the lf map and walks it, each step paced by the registered memory reads
// a status block gives its single item from S_STAT through the output register
// after reset a pass over all 256 symbols clears the symbol counts; no item is taken then
// out_tready low holds the walk; the output register lets one item wait
module burrows_wheeler_inverse_unit import bwi_pkg::*; #(
  parameter int BLOCK_BYTES = BWI_BLOCK_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [2:0] out_tuser   // [2:0] status
);

  localparam int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int LW = $clog2(BLOCK_BYTES + 1);
  localparam int CW = $clog2(BLOCK_BYTES + HDR_BYTES + 1);
  localparam logic [CW-1:0] HDR_C = CW'(HDR_BYTES);
  localparam logic [CW-1:0] CAP_C = CW'(BLOCK_BYTES + HDR_BYTES);

  logic [HDR_W-1:0] hdr_r, hdr_upd, hdr_nxt;
  logic [CW-1:0]    bc_r, bc_upd, bc_nxt;
  logic             ovf_r, ovf_upd, ovf_nxt;

  logic          in_acc;
  logic          lc_we;
  logic [AW-1:0] lc_waddr;
  blk_req_t      req;
  logic [LW-1:0] req_len;
  logic [AW-1:0] req_start;
  logic          seq_rdy;
  logic          push, push_ok;
  out_item_t     push_item, out_item;

  assign in_tready = seq_rdy;
  assign in_acc    = in_tvalid && in_tready;
  assign lc_waddr  = AW'(bc_r - HDR_C);
  assign req_len   = LW'(bc_upd - HDR_C);
  assign req_start = hdr_upd[AW-1:0];

  always_comb begin
    hdr_upd = hdr_r;
    bc_upd  = bc_r;
    ovf_upd = ovf_r;
    lc_we   = 1'b0;
    if (in_acc) begin
      if (bc_r < HDR_C) begin
        hdr_upd = {hdr_r[HDR_W-9:0], in_tdata};
        bc_upd  = bc_r + CW'(1);
      end else if (bc_r < CAP_C) begin
        lc_we  = 1'b1;
        bc_upd = bc_r + CW'(1);
      end else begin
        ovf_upd = 1'b1;
      end
    end
  end

  always_comb begin
    req.go     = in_acc && in_tlast;
    req.status = ST_DATA;
    priority if (bc_upd < HDR_C) begin
      req.status = ST_SHORT;
    end else if (ovf_upd) begin
      req.status = ST_OVERFLOW;
    end else if (req_len == '0) begin
      req.status = ST_EMPTY;
    end else if (hdr_upd >= HDR_W'(req_len)) begin
      req.status = ST_BAD_INDEX;
    end else begin
      req.status = ST_DATA;
    end
    hdr_nxt = req.go ? '0 : hdr_upd;
    bc_nxt  = req.go ? '0 : bc_upd;
    ovf_nxt = req.go ? 1'b0 : ovf_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= '0;
      bc_r  <= '0;
      ovf_r <= 1'b0;
    end else begin
      hdr_r <= hdr_nxt;
      bc_r  <= bc_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  bwi_seq #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .AW         (AW),
    .LW         (LW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .lc_we    (lc_we),
    .lc_waddr (lc_waddr),
    .lc_wdata (in_tdata),
    .req      (req),
    .req_len  (req_len),
    .req_start(req_start),
    .rdy      (seq_rdy),
    .push     (push),
    .push_item(push_item),
    .push_ok  (push_ok)
  );

  bwi_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .push_ok  (push_ok),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_item (out_item)
  );

  assign out_tdata = out_item.data;
  assign out_tlast = out_item.last;
  assign out_tuser = out_item.status;

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_DATA) |-> (out_tdata == '0) && out_tlast)
    else $error("status item with data or without last");

  a_busy_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> !in_tready)
    else $error("input taken while block decodes");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bc_r <= CAP_C)
    else $error("byte count beyond capacity");

endmodule
